>>> hw/rtl/mlr_pkg.sv
package mlr_pkg;

    // field widths fixed by the pixel interface
    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 24;

    // widest internal coordinate supported by the core
    localparam int COORD_MAX = 16;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // front-to-back queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } t_pixel;

    // classified command as it travels from front to back
    typedef struct packed {
        logic                 is_next;
        logic [COORD_MAX-1:0] x0;
        logic [COORD_MAX-1:0] y0;
        logic [COORD_MAX-1:0] major_end;
        logic [COORD_MAX-1:0] dmaj;
        logic [COORD_MAX-1:0] dmin;
        logic                 step_xn;
        logic                 step_yn;
        logic                 x_major;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

endpackage

>>> hw/rtl/mlr_front.sv
module mlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mlr_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output mlr_pkg::t_cmd  o_cmd
);

    localparam int CB = COORD_BITS;
    localparam int CM = mlr_pkg::COORD_MAX;

    logic          r_vld;
    mlr_pkg::t_cmd r_cmd;
    mlr_pkg::t_cmd n_cmd;

    logic [CB-1:0] w_x0;
    logic [CB-1:0] w_y0;
    logic [CB-1:0] w_x1;
    logic [CB-1:0] w_y1;
    logic [CB-1:0] w_dx;
    logic [CB-1:0] w_dy;
    logic          w_x_major;

    // classify the beat and work out deltas, directions and major axis
    always_comb begin
        w_x0      = CB'(i_item.x_start);
        w_y0      = CB'(i_item.y_start);
        w_x1      = CB'(i_item.x_end);
        w_y1      = CB'(i_item.y_end);
        w_dx      = (w_x1 > w_x0) ? (w_x1 - w_x0) : (w_x0 - w_x1);
        w_dy      = (w_y1 > w_y0) ? (w_y1 - w_y0) : (w_y0 - w_y1);
        w_x_major = (w_dx > w_dy);

        n_cmd.is_next   = (i_item.command == mlr_pkg::CMD_NEXT);
        n_cmd.x0        = CM'(w_x0);
        n_cmd.y0        = CM'(w_y0);
        n_cmd.major_end = w_x_major ? CM'(w_x1) : CM'(w_y1);
        n_cmd.dmaj      = w_x_major ? CM'(w_dx) : CM'(w_dy);
        n_cmd.dmin      = w_x_major ? CM'(w_dy) : CM'(w_dx);
        n_cmd.step_xn   = !(w_x0 < w_x1);
        n_cmd.step_yn   = !(w_y0 < w_y1);
        n_cmd.x_major   = w_x_major;
        n_cmd.color     = i_item.color;
    end

    // hold the stage only while the queue refuses it
    assign o_stall = r_vld & i_stall;
    assign o_valid = r_vld;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hw/rtl/mlr_queue.sv
module mlr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mlr_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output mlr_pkg::t_cmd o_cmd
);

    localparam int PW = mlr_pkg::Q_PTR_W;
    localparam int CW = mlr_pkg::Q_CNT_W;

    mlr_pkg::t_cmd r_slot [mlr_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_stall = (r_count == CW'(mlr_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_valid & !o_stall;
    assign w_pop   = o_valid & !i_stall;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // store the incoming beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/mlr_back.sv
module mlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mlr_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_stall,
    output mlr_pkg::t_pixel o_pixel
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int CW = mlr_pkg::COORD_W;

    logic [CB-1:0]                r_cur_x;
    logic [CB-1:0]                r_cur_y;
    logic [CB-1:0]                r_major_end;
    logic signed [DW-1:0]         r_decision;
    logic signed [DW-1:0]         r_inc_s;
    logic signed [DW-1:0]         r_inc_d;
    logic                         r_step_xn;
    logic                         r_step_yn;
    logic                         r_x_major;
    logic                         r_active;
    logic [mlr_pkg::COLOR_W-1:0]  r_color;
    logic                         r_out_vld;
    mlr_pkg::t_pixel              r_out;

    logic [CB-1:0]                n_cur_x;
    logic [CB-1:0]                n_cur_y;
    logic [CB-1:0]                n_major_end;
    logic signed [DW-1:0]         n_decision;
    logic signed [DW-1:0]         n_inc_s;
    logic signed [DW-1:0]         n_inc_d;
    logic                         n_step_xn;
    logic                         n_step_yn;
    logic                         n_x_major;
    logic                         n_active;
    logic [mlr_pkg::COLOR_W-1:0]  n_color;
    mlr_pkg::t_pixel              n_out;

    logic                         w_take;
    logic                         w_emit;
    logic                         w_diag;
    logic                         w_last;
    logic [CB-1:0]                w_dmaj;
    logic [CB-1:0]                w_dmin;
    logic [CB-1:0]                w_x_step;
    logic [CB-1:0]                w_y_step;

    assign o_stall = r_out_vld & i_stall;
    assign w_take  = i_valid & !o_stall;
    assign w_emit  = w_take & (!i_cmd.is_next | r_active);
    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

    // execute a start or one pixel step on the line state
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_major_end = r_major_end;
        n_decision  = r_decision;
        n_inc_s     = r_inc_s;
        n_inc_d     = r_inc_d;
        n_step_xn   = r_step_xn;
        n_step_yn   = r_step_yn;
        n_x_major   = r_x_major;
        n_active    = r_active;
        n_color     = r_color;
        w_last      = 1'b0;

        w_dmaj   = CB'(i_cmd.dmaj);
        w_dmin   = CB'(i_cmd.dmin);
        w_diag   = r_decision[DW-1];
        w_x_step = r_step_xn ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
        w_y_step = r_step_yn ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);

        if (!i_cmd.is_next) begin
            // load a new line and show its first point
            n_cur_x     = CB'(i_cmd.x0);
            n_cur_y     = CB'(i_cmd.y0);
            n_major_end = CB'(i_cmd.major_end);
            n_decision  = DW'(w_dmaj) - DW'({w_dmin, 1'b0});
            n_inc_s     = -DW'({w_dmin, 1'b0});
            n_inc_d     = DW'({CB'(w_dmaj - w_dmin), 1'b0});
            n_step_xn   = i_cmd.step_xn;
            n_step_yn   = i_cmd.step_yn;
            n_x_major   = i_cmd.x_major;
            n_color     = i_cmd.color;
            w_last      = (w_dmaj == '0);
            n_active    = !w_last;
        end else if (r_active) begin
            // straight or diagonal step along the major axis
            n_decision = r_decision + (w_diag ? r_inc_d : r_inc_s);
            if (r_x_major || w_diag) begin
                n_cur_x = w_x_step;
            end
            if (!r_x_major || w_diag) begin
                n_cur_y = w_y_step;
            end
            w_last   = r_x_major ? (n_cur_x == r_major_end) : (n_cur_y == r_major_end);
            n_active = !w_last;
        end

        n_out.pixel_x     = CW'(n_cur_x);
        n_out.pixel_y     = CW'(n_cur_y);
        n_out.pixel_color = n_color;
        n_out.last_pixel  = w_last;
    end

    // update line state on each taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_major_end <= '0;
            r_decision  <= '0;
            r_inc_s     <= '0;
            r_inc_d     <= '0;
            r_step_xn   <= 1'b0;
            r_step_yn   <= 1'b0;
            r_x_major   <= 1'b0;
            r_active    <= 1'b0;
            r_color     <= '0;
        end else if (w_take) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_major_end <= n_major_end;
            r_decision  <= n_decision;
            r_inc_s     <= n_inc_s;
            r_inc_d     <= n_inc_d;
            r_step_xn   <= n_step_xn;
            r_step_yn   <= n_step_yn;
            r_x_major   <= n_x_major;
            r_active    <= n_active;
            r_color     <= n_color;
        end
    end

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!o_stall) begin
            r_out_vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer. A start beat (command 0) loads two endpoints and a
// color and yields the start pixel; each next beat (command 1) yields one more
// pixel of the line, with last_pixel set on the end point. A line whose
// endpoints share the major coordinate gives one pixel flagged last. A next
// beat with no line in progress yields nothing; a start beat drops any line
// in progress. The block takes one beat per clock and gives one pixel per
// clock while the output is not stalled, limited by the error-term add and step
// in the back end. An accepted beat passes the classify register, the two-entry
// command queue and the output register before its pixel shows. The input side
// keeps taking beats while a pixel waits on a stalled output, until the queue
// and the classify register are full. COORD_BITS sets the internal coordinate
// width (up to 16); coordinates are taken in their low COORD_BITS.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mlr_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output mlr_pkg::t_pixel o_pixel
);

    logic          w_fq_valid;
    logic          w_fq_stall;
    mlr_pkg::t_cmd w_fq_cmd;
    logic          w_qb_valid;
    logic          w_qb_stall;
    mlr_pkg::t_cmd w_qb_cmd;

    // classify commands and set up line deltas
    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (w_fq_valid),
        .i_stall (w_fq_stall),
        .o_cmd   (w_fq_cmd)
    );

    // decouple front and back
    mlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_stall (w_fq_stall),
        .i_cmd   (w_fq_cmd),
        .o_valid (w_qb_valid),
        .i_stall (w_qb_stall),
        .o_cmd   (w_qb_cmd)
    );

    // step the line and drive pixels
    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_stall (w_qb_stall),
        .i_cmd   (w_qb_cmd),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

endmodule

>>> hw/rtl/mlr_checker.sv
module mlr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input mlr_pkg::t_pixel o_pixel
);

    // a stalled pixel beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel)))
        else $error("pixel beat changed while stalled");

    // no pixel is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("pixel valid right after reset");

    // the input side backs up only behind a stalled pixel
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pixel (o_pixel)
);

>>> tb/sv/tb_midpoint_line_rasterizer.sv
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer;

    localparam int   COORD_W     = mlr_pkg::COORD_W;
    localparam int   COLOR_W     = mlr_pkg::COLOR_W;
    localparam logic CMD_START   = mlr_pkg::CMD_START;
    localparam logic CMD_NEXT    = mlr_pkg::CMD_NEXT;

    localparam int COORD_TOP    = (1 << COORD_W) - 1;
    localparam int RAND_BEATS   = 820;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 10;

    // one row of the directed table: a beat, and optionally a hand-written outcome
    typedef struct {
        mlr_pkg::t_item  beat;
        bit              typed;
        bit              gives;
        mlr_pkg::t_pixel pix;
    } t_dir_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    mlr_pkg::t_item  i_item;
    logic            o_valid;
    logic            i_stall;
    mlr_pkg::t_pixel o_pixel;

    midpoint_line_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    // line tracer state
    logic [COORD_W-1:0] ln_x, ln_y, ln_major_end;
    logic signed [14:0] ln_err, ln_inc_str, ln_inc_diag;
    logic               ln_xneg, ln_yneg, ln_xmajor, ln_active;
    logic [COLOR_W-1:0] ln_color;

    mlr_pkg::t_pixel pending_pixels[$];
    t_dir_row        dir_rows[$];

    int  err_count;
    int  beats_sent;
    int  lines_started;
    int  pixels_made;
    int  pixels_checked;
    int  line_ends_seen;
    int  cycle_count = 0;
    bit  calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance the tracer by one beat; return 1 when the beat yields a pixel.
    function automatic bit trace_line_step(input mlr_pkg::t_item b,
                                           output mlr_pkg::t_pixel pix);
        logic [COORD_W-1:0] x0, y0, x1, y1;
        int dx, dy, dmaj, dmin;
        bit diag, fin;
        pix = '0;
        if (b.command == CMD_START) begin
            x0 = b.x_start;
            y0 = b.y_start;
            x1 = b.x_end;
            y1 = b.y_end;
            dx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
            dy = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
            ln_x      = x0;
            ln_y      = y0;
            ln_color  = b.color;
            ln_xneg   = !(x0 < x1);
            ln_yneg   = !(y0 < y1);
            ln_xmajor = dx > dy;
            dmaj = ln_xmajor ? dx : dy;
            dmin = ln_xmajor ? dy : dx;
            ln_major_end = ln_xmajor ? x1 : y1;
            // equal endpoints give a single pixel and leave no line open
            fin = (dmaj == 0);
            ln_err      = 15'(dmaj - 2 * dmin);
            ln_inc_str  = 15'(-2 * dmin);
            ln_inc_diag = 15'(2 * (dmaj - dmin));
            ln_active   = !fin;
        end else begin
            if (!ln_active)
                return 1'b0;
            // negative error term takes the diagonal step
            diag = ln_err < 0;
            ln_err = ln_err + (diag ? ln_inc_diag : ln_inc_str);
            if (ln_xmajor || diag)
                ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
            if (!ln_xmajor || diag)
                ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
            fin = ln_xmajor ? (ln_x == ln_major_end) : (ln_y == ln_major_end);
            if (fin)
                ln_active = 1'b0;
        end
        pix.pixel_x     = ln_x;
        pix.pixel_y     = ln_y;
        pix.pixel_color = ln_color;
        pix.last_pixel  = fin;
        return 1'b1;
    endfunction

    function automatic mlr_pkg::t_item mk_beat(input logic cmd, input int x0, input int y0,
                                               input int x1, input int y1, input int col);
        mlr_pkg::t_item b;
        b.command = cmd;
        b.x_start = x0[COORD_W-1:0];
        b.y_start = y0[COORD_W-1:0];
        b.x_end   = x1[COORD_W-1:0];
        b.y_end   = y1[COORD_W-1:0];
        b.color   = col[COLOR_W-1:0];
        return b;
    endfunction

    function automatic mlr_pkg::t_pixel mk_pixel(input int x, input int y, input int col,
                                                 input bit fin);
        mlr_pkg::t_pixel p;
        p.pixel_x     = x[COORD_W-1:0];
        p.pixel_y     = y[COORD_W-1:0];
        p.pixel_color = col[COLOR_W-1:0];
        p.last_pixel  = fin;
        return p;
    endfunction

    function automatic t_dir_row fixed_row(input mlr_pkg::t_item b, input bit gives,
                                           input mlr_pkg::t_pixel p);
        t_dir_row r;
        r.beat  = b;
        r.typed = 1'b1;
        r.gives = gives;
        r.pix   = p;
        return r;
    endfunction

    function automatic t_dir_row traced_row(input mlr_pkg::t_item b);
        t_dir_row r;
        r.beat  = b;
        r.typed = 1'b0;
        r.gives = 1'b0;
        r.pix   = '0;
        return r;
    endfunction

    // every field random; used for next beats and noise
    function automatic mlr_pkg::t_item junk_beat(input logic cmd);
        mlr_pkg::t_item b;
        b.command = cmd;
        b.x_start = COORD_W'($urandom_range(0, COORD_TOP));
        b.y_start = COORD_W'($urandom_range(0, COORD_TOP));
        b.x_end   = COORD_W'($urandom_range(0, COORD_TOP));
        b.y_end   = COORD_W'($urandom_range(0, COORD_TOP));
        b.color   = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
        return b;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 20)
            return COORD_TOP;
        return $urandom_range(0, COORD_TOP);
    endfunction

    function automatic int offset_coord(input int base, input int span);
        int d;
        int v;
        d = $urandom_range(0, span);
        v = $urandom_range(0, 1) ? base + d : base - d;
        if (v < 0)
            v = 0;
        if (v > COORD_TOP)
            v = COORD_TOP;
        return v;
    endfunction

    // Present one beat and hold it until it is taken.
    task automatic drive_beat(input mlr_pkg::t_item b);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_item  <= junk_beat(1'($urandom_range(0, 1)));
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Send one row and queue what it should produce.
    task automatic feed(input t_dir_row row);
        mlr_pkg::t_pixel pix;
        bit              gives;
        drive_beat(row.beat);
        beats_sent++;
        if (row.beat.command == CMD_START)
            lines_started++;
        gives = trace_line_step(row.beat, pix);
        if (row.typed) begin
            gives = row.gives;
            pix   = row.pix;
        end
        if (gives) begin
            pending_pixels.push_back(pix);
            pixels_made++;
        end
    endtask

    // Hold off the input side until every queued pixel has come out.
    task automatic drain_pixels();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() > 0)
            @(posedge i_clk);
    endtask

    // output stall: random runs; no new stall run starts while calm
    initial begin : out_stall
        int  run;
        bit  hold;
        run  = 0;
        hold = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                hold = calm ? 1'b0 : ($urandom_range(0, 3) == 0);
                run  = hold ? 1 + pick_gap() : $urandom_range(1, 6);
            end
            i_stall <= hold;
            run--;
        end
    end

    task automatic flag_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        err_count++;
    endtask

    // check each accepted pixel against the oldest expectation
    always @(posedge i_clk) begin
        mlr_pkg::t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected pixel, expected none, got %h", $time, o_pixel);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel.pixel_x !== want.pixel_x)
                    flag_field("pixel_x", want.pixel_x, o_pixel.pixel_x);
                if (o_pixel.pixel_y !== want.pixel_y)
                    flag_field("pixel_y", want.pixel_y, o_pixel.pixel_y);
                if (o_pixel.pixel_color !== want.pixel_color)
                    flag_field("pixel_color", want.pixel_color, o_pixel.pixel_color);
                if (o_pixel.last_pixel !== want.last_pixel)
                    flag_field("last_pixel", want.last_pixel, o_pixel.last_pixel);
                pixels_checked++;
                if (o_pixel.last_pixel)
                    line_ends_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        mlr_pkg::t_item b;
        int    r, x0, y0, x1, y1, steps, nexts, line_no, target;
        bit    wide_line;

        err_count      = 0;
        beats_sent     = 0;
        lines_started  = 0;
        pixels_made    = 0;
        pixels_checked = 0;
        line_ends_seen = 0;
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_item         = '0;

        // tracer starts from the reset state: no line open
        ln_x         = '0;
        ln_y         = '0;
        ln_major_end = '0;
        ln_err       = '0;
        ln_inc_str   = '0;
        ln_inc_diag  = '0;
        ln_xneg      = 1'b0;
        ln_yneg      = 1'b0;
        ln_xmajor    = 1'b0;
        ln_active    = 1'b0;
        ln_color     = '0;

        // directed table
        dir_rows.push_back(fixed_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 0, 0, 0, 0, 0), 1'b1,
                                     mk_pixel(0, 0, 0, 1'b1)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 4095, 4095, 4095, 4095, 'hFFFFFF),
                                     1'b1, mk_pixel(4095, 4095, 'hFFFFFF, 1'b1)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_NEXT, 4095, 4095, 4095, 4095, 'hFFFFFF),
                                     1'b0, '0));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 0, 0, 4095, 0, 'h123456), 1'b1,
                                     mk_pixel(0, 0, 'h123456, 1'b0)));
        dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 4095, 4095, 0, 0, 'hABCDEF), 1'b1,
                                     mk_pixel(4095, 4095, 'hABCDEF, 1'b0)));
        dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 4095, 4095, 4095, 4095, 'hFFFFFF)));
        dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 10, 20, 12, 20, 'h0F0F0F), 1'b1,
                                     mk_pixel(10, 20, 'h0F0F0F, 1'b0)));
        dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 7, 7, 7, 4, 'hF0F0F0), 1'b1,
                                     mk_pixel(7, 7, 'hF0F0F0, 1'b0)));
        repeat (3)
            dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 0, 4095, 3, 4094, 'h5A5A5A), 1'b1,
                                     mk_pixel(0, 4095, 'h5A5A5A, 1'b0)));
        repeat (3)
            dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));
        dir_rows.push_back(fixed_row(mk_beat(CMD_START, 20, 0, 18, 5, 'hA5A5A5), 1'b1,
                                     mk_pixel(20, 0, 'hA5A5A5, 1'b0)));
        repeat (3)
            dir_rows.push_back(traced_row(mk_beat(CMD_NEXT, 0, 0, 0, 0, 0)));

        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            feed(dir_rows[k]);
        drain_pixels();

        // random lines: mostly complete, some overrun or abandoned, some noise
        target  = beats_sent + RAND_BEATS;
        line_no = 0;
        while (beats_sent < target) begin
            line_no++;
            calm = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                feed(traced_row(junk_beat(1'($urandom_range(0, 1)))));
            end else begin
                wide_line = (r >= 92);
                x0 = pick_coord();
                y0 = pick_coord();
                x1 = offset_coord(x0, wide_line ? COORD_TOP : $urandom_range(0, 12));
                y1 = offset_coord(y0, wide_line ? COORD_TOP : $urandom_range(0, 12));
                steps = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps)
                    steps = (y1 > y0) ? y1 - y0 : y0 - y1;
                r = $urandom_range(0, 99);
                if (wide_line)
                    nexts = $urandom_range(1, 30);
                else if (r < 75)
                    nexts = steps;
                else if (r < 87)
                    nexts = steps + $urandom_range(1, 2);
                else
                    nexts = $urandom_range(0, steps);
                b = mk_beat(CMD_START, x0, y0, x1, y1, 0);
                b.color = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
                feed(traced_row(b));
                repeat (nexts)
                    feed(traced_row(junk_beat(CMD_NEXT)));
            end
            // let the pipeline run dry now and then
            if (line_no % 40 == 20)
                drain_pixels();
        end

        // wind down
        calm = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats over %0d line starts; checked %0d pixels, %0d line ends.",
                 beats_sent, lines_started, pixels_checked, line_ends_seen);
        $display("Lines ran in all octants, including degenerate, overrun and abandoned ones.");
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
